// ----- hdl/cpvs_pkg.sv -----
// Package for the clock page victim selector: widths, register indexes,
// class codes, command/status structs and a score helper function.
// No dependencies.
`timescale 1ns / 1ps
package cpvs_pkg;

    localparam int FRAME_SLOTS = 16;
    localparam int IDX_W       = $clog2(FRAME_SLOTS);
    localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
    localparam int TIME_W      = 48;
    localparam int WGT_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SCORE_W     = 36;
    localparam int AGE_SPAN    = 1000;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_W_FREQ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_RECENCY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_TIER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W_CLEAN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W_UNREF     = 3'd5;

    localparam logic [1:0] CLASS_WRITE = 2'd0;
    localparam logic [1:0] CLASS_CLEAN = 2'd1;
    localparam logic [1:0] CLASS_DIRTY = 2'd2;
    localparam logic [1:0] CLASS_SCORE = 2'd3;

    // datapath commands from the controller
    typedef struct packed {
        logic             write_entry;  // store the input entry
        logic             load_req;     // latch time, clamp hand, clear search
        logic             scan;         // examine slot r_pos in current round
        logic             round2;       // 0 clean round, 1 dirty round
        logic             clr_ref;      // clear reference bit of slot r_pos
        logic             score;        // score slot r_pos (issue stage)
        logic             pos_reset;    // set position to start
        logic             from_hand;    // start at hand (else slot 0)
        logic             take_hit;     // move hand after hit
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic             hit;          // current scan slot matches
        logic             last;         // position at final slot of the walk
        logic             empty;        // sweep size is zero
        logic             found;        // scoring found an eligible frame
        logic [IDX_W-1:0] pos;          // current slot
    } t_sts;

    function automatic logic [16:0] tier_of(input logic [1:0] t);
        logic [16:0] v;
        unique case (t)
            2'd0: v = 17'd6554;
            2'd1: v = 17'd26214;
            2'd2: v = 17'd45875;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/clock_page_victim_select.sv -----
// Top level of the clock page victim selector: joins controller and datapath.
// Depends on cpvs_pkg, cpvs_ctrl, cpvs_dp.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  request | i_start / o_busy    | i_req_type, i_frame_index, i_entry_*,
//          |                     | i_now_time
//  result  | o_done (one cycle)  | o_victim_found, o_victim_frame, o_victim_class
//  config  | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// An entry write stores the entry and then shows its result. A victim request
// walks up to four sweep rounds (n = frames in use each) and then drains the
// 4-stage score pipeline; the walk goes over the table one slot per cycle.
// Reset (i_rst_n low, synchronous) empties every frame and sets the hand to 0.
// Results cannot be stalled; o_busy stays high until the result cycle ends.
`timescale 1ns / 1ps
module clock_page_victim_select (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_cfg_we,
    input  logic [cpvs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cpvs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_req_type,
    input  logic [3:0]                    i_frame_index,
    input  logic                          i_entry_occupied,
    input  logic                          i_entry_pinned,
    input  logic                          i_entry_referenced,
    input  logic                          i_entry_modified,
    input  logic [1:0]                    i_entry_tier,
    input  logic [7:0]                    i_entry_use_count,
    input  logic [47:0]                   i_entry_last_access,
    input  logic [47:0]                   i_now_time,
    output logic                          o_done,
    output logic                          o_victim_found,
    output logic [3:0]                    o_victim_frame,
    output logic [1:0]                    o_victim_class
);
    import cpvs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_go;

    assign w_go = i_start && !o_busy;

    cpvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_found    (o_victim_found),
        .o_class    (o_victim_class),
        .o_frame    (o_victim_frame)
    );

    cpvs_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_frame_index       (i_frame_index),
        .i_entry_occupied    (i_entry_occupied),
        .i_entry_pinned      (i_entry_pinned),
        .i_entry_referenced  (i_entry_referenced),
        .i_entry_modified    (i_entry_modified),
        .i_entry_tier        (i_entry_tier),
        .i_entry_use_count   (i_entry_use_count),
        .i_entry_last_access (i_entry_last_access),
        .i_now_time          (i_now_time)
    );

`ifndef SYNTHESIS
    a_done_after_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result shown while idle");
    a_none_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_victim_found) |-> (o_victim_frame == '0))
        else $error("frame set without victim");
    a_busy_no_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> o_busy)
        else $error("accepted item did not raise busy");
`endif

endmodule

// ----- hdl/cpvs_ctrl.sv -----
// Controller of the clock page victim selector: sequences entry writes,
// two sweep rounds, the reference clear round and the scoring pass.
// Depends on cpvs_pkg.
`timescale 1ns / 1ps
module cpvs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic              i_req_type,
    input  cpvs_pkg::t_sts    i_sts,
    output cpvs_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_done,
    output logic              o_found,
    output logic [1:0]        o_class,
    output logic [cpvs_pkg::IDX_W-1:0] o_frame
);
    import cpvs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_R1    = 3'd2;
    localparam logic [2:0] ST_R2    = 3'd3;
    localparam logic [2:0] ST_CLR   = 3'd4;
    localparam logic [2:0] ST_SCORE = 3'd5;
    localparam logic [2:0] ST_DRAIN = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [1:0]       r_drain, n_drain;
    logic             r_done, n_done;
    logic             r_found, n_found;
    logic [1:0]       r_class, n_class;
    logic [IDX_W-1:0] r_frame, n_frame;

    // next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_drain = r_drain;
        n_done  = 1'b0;
        n_found = r_found;
        n_class = r_class;
        n_frame = r_frame;
        unique case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    if (!i_req_type) begin
                        o_cmd.write_entry = 1'b1;
                        n_done  = 1'b1;
                        n_found = 1'b0;
                        n_class = CLASS_WRITE;
                        n_frame = '0;
                    end else begin
                        o_cmd.load_req = 1'b1;
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                if (i_sts.empty) begin
                    n_done  = 1'b1;
                    n_found = 1'b0;
                    n_class = CLASS_SCORE;
                    n_frame = '0;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.pos_reset = 1'b1;
                    o_cmd.from_hand = 1'b1;
                    n_state = ST_R1;
                end
            end
            ST_R1, ST_R2: begin
                o_cmd.scan   = 1'b1;
                o_cmd.round2 = (r_state == ST_R2);
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_class = (r_state == ST_R2) ? CLASS_DIRTY : CLASS_CLEAN;
                    n_frame = i_sts.pos;
                    n_state = ST_IDLE;
                end else if (i_sts.last) begin
                    o_cmd.pos_reset = 1'b1;
                    o_cmd.from_hand = (r_state == ST_R1);
                    n_state = (r_state == ST_R1) ? ST_R2 : ST_CLR;
                end
            end
            ST_CLR: begin
                o_cmd.clr_ref = 1'b1;
                if (i_sts.last) begin
                    o_cmd.pos_reset = 1'b1;
                    n_state = ST_SCORE;
                end
            end
            ST_SCORE: begin
                o_cmd.score = 1'b1;
                if (i_sts.last) begin
                    n_drain = 2'd3;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // let the score pipeline empty
                n_drain = r_drain - 2'd1;
                if (r_drain == 2'd0) begin
                    n_done  = 1'b1;
                    n_found = i_sts.found;
                    n_class = CLASS_SCORE;
                    n_frame = i_sts.found ? i_sts.pos : '0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_drain <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_class <= n_class;
        r_frame <= n_frame;
    end

    assign o_busy  = (r_state != ST_IDLE) || r_done;
    assign o_done  = r_done;
    assign o_found = r_found;
    assign o_class = r_class;
    assign o_frame = r_frame;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held two cycles");
    a_no_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd.write_entry)
        else $error("entry write during search");
    a_hit_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_found |-> r_class != CLASS_WRITE)
        else $error("victim reported with write class");
`endif

endmodule

// ----- hdl/cpvs_dp.sv -----
// Datapath of the clock page victim selector: frame table, hand, walk
// position, weight registers and a pipelined score/compare unit.
// Depends on cpvs_pkg.
`timescale 1ns / 1ps
module cpvs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpvs_pkg::t_cmd                i_cmd,
    output cpvs_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [cpvs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cpvs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [cpvs_pkg::IDX_W-1:0]    i_frame_index,
    input  logic                          i_entry_occupied,
    input  logic                          i_entry_pinned,
    input  logic                          i_entry_referenced,
    input  logic                          i_entry_modified,
    input  logic [1:0]                    i_entry_tier,
    input  logic [7:0]                    i_entry_use_count,
    input  logic [cpvs_pkg::TIME_W-1:0]   i_entry_last_access,
    input  logic [cpvs_pkg::TIME_W-1:0]   i_now_time
);
    import cpvs_pkg::*;

    logic [FRAME_SLOTS-1:0] r_occ, r_pin, r_ref, r_mod;
    logic [1:0]       r_tier [FRAME_SLOTS];
    logic [7:0]       r_cnt  [FRAME_SLOTS];
    logic [TIME_W-1:0] r_last [FRAME_SLOTS];
    logic [IDX_W-1:0] r_hand, r_pos;
    logic [CNT_W-1:0] r_n;
    logic [4:0]       r_frames;
    logic [WGT_W-1:0] r_wf, r_wr, r_wt, r_wc, r_wu;
    logic [TIME_W-1:0] r_now;

    logic [CNT_W-1:0] w_n;
    logic [IDX_W-1:0] w_pos_nx, w_end;
    logic             w_elig;
    logic [16:0]      w_freq_tab [256];

    // frequency component table: floor(65536 / (1 + count))
    for (genvar gi = 0; gi < 256; gi++) begin : g_freq
        localparam logic [16:0] FREQ_VAL = 17'(65536 / (gi + 1));
        assign w_freq_tab[gi] = FREQ_VAL;
    end

    // clamp sweep size to the table
    assign w_n = (r_frames > 5'(FRAME_SLOTS)) ? CNT_W'(FRAME_SLOTS) : CNT_W'(r_frames);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= 5'd16;
            r_wf <= 16'd4096;
            r_wr <= 16'd4096;
            r_wt <= 16'd4096;
            r_wc <= 16'd4096;
            r_wu <= 16'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAMES:    r_frames <= i_cfg_data[4:0];
                REG_W_FREQ:    r_wf <= i_cfg_data;
                REG_W_RECENCY: r_wr <= i_cfg_data;
                REG_W_TIER:    r_wt <= i_cfg_data;
                REG_W_CLEAN:   r_wc <= i_cfg_data;
                REG_W_UNREF:   r_wu <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_elig   = r_occ[r_pos] && !r_pin[r_pos];
    assign w_pos_nx = (CNT_W'(r_pos) + 1'b1 >= r_n) ? '0 : r_pos + 1'b1;
    // a walk from the hand ends just before it
    assign w_end    = i_cmd.scan ? ((r_hand == '0) ? IDX_W'(r_n - 1'b1) : r_hand - 1'b1)
                                 : IDX_W'(r_n - 1'b1);

    // flag bits, hand and walk position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_pin  <= '0;
            r_ref  <= '0;
            r_mod  <= '0;
            r_hand <= '0;
            r_pos  <= '0;
            r_n    <= '0;
        end else begin
            if (i_cmd.write_entry) begin
                r_occ[i_frame_index] <= i_entry_occupied;
                r_pin[i_frame_index] <= i_entry_pinned;
                r_ref[i_frame_index] <= i_entry_referenced;
                r_mod[i_frame_index] <= i_entry_modified;
            end
            // an empty sweep leaves the hand alone
            if (i_cmd.load_req) begin
                r_n <= w_n;
                if ((w_n != '0) && (CNT_W'(r_hand) >= w_n))
                    r_hand <= '0;
            end
            if (i_cmd.clr_ref && w_elig)
                r_ref[r_pos] <= 1'b0;
            if (i_cmd.take_hit)
                r_hand <= w_pos_nx;
            if (i_cmd.pos_reset)
                r_pos <= i_cmd.from_hand ? r_hand : '0;
            else if (i_cmd.scan || i_cmd.clr_ref || i_cmd.score)
                r_pos <= w_pos_nx;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_SLOTS; i++) begin
                r_tier[i] <= '0;
                r_cnt[i]  <= '0;
                r_last[i] <= '0;
            end
        end else if (i_cmd.write_entry) begin
            r_tier[i_frame_index] <= i_entry_tier;
            r_cnt[i_frame_index]  <= i_entry_use_count;
            r_last[i_frame_index] <= i_entry_last_access;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req)
            r_now <= i_now_time;
    end

    // score stage 1: components
    logic             s1_v;
    logic [IDX_W-1:0] s1_idx;
    logic [16:0]      s1_freq, s1_tier;
    logic             s1_clean, s1_unref, s1_sat;
    logic [9:0]       s1_age;
    logic [TIME_W:0]  w_age;
    assign w_age = {1'b0, r_now} - {1'b0, r_last[r_pos]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            s1_v <= 1'b0;
        else
            s1_v <= i_cmd.score && w_elig;
        s1_idx   <= r_pos;
        s1_freq  <= w_freq_tab[r_cnt[r_pos]];
        s1_tier  <= tier_of(r_tier[r_pos]);
        s1_clean <= !r_mod[r_pos];
        s1_unref <= !r_ref[r_pos];
        s1_sat   <= !w_age[TIME_W] && (w_age[TIME_W-1:0] >= TIME_W'(AGE_SPAN));
        s1_age   <= w_age[TIME_W] ? 10'd0 : w_age[9:0];
    end

    // score stage 2: recency by reciprocal, age below 1000
    logic             s2_v;
    logic [IDX_W-1:0] s2_idx;
    logic [16:0]      s2_freq, s2_tier, s2_rec;
    logic             s2_clean, s2_unref;
    logic [25:0]      w_prod;
    logic [16:0]      w_q;
    // age*65536/1000 = age*8192/125; ceil(2^30/125) gives the exact floor
    // for every product below 2^23
    assign w_prod = {s1_age, 16'd0} >> 3;      // age*8192
    assign w_q    = 17'((49'(w_prod) * 49'd8589935) >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            s2_v <= 1'b0;
        else
            s2_v <= s1_v;
        s2_idx   <= s1_idx;
        s2_freq  <= s1_freq;
        s2_tier  <= s1_tier;
        s2_clean <= s1_clean;
        s2_unref <= s1_unref;
        s2_rec   <= s1_sat ? 17'd65536 : w_q;
    end

    // score stage 3: weighted products
    logic             s3_v;
    logic [IDX_W-1:0] s3_idx;
    logic [32:0]      s3_pf, s3_pr, s3_pt, s3_pb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            s3_v <= 1'b0;
        else
            s3_v <= s2_v;
        s3_idx <= s2_idx;
        s3_pf  <= 33'(r_wf) * 33'(s2_freq);
        s3_pr  <= 33'(r_wr) * 33'(s2_rec);
        s3_pt  <= 33'(r_wt) * 33'(s2_tier);
        s3_pb  <= {1'b0, (s2_clean ? r_wc : 16'd0), 16'd0}
                + {1'b0, (s2_unref ? r_wu : 16'd0), 16'd0};
    end

    // score stage 4: sum and keep best, first wins on tie
    logic [SCORE_W-1:0] w_sum, r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_found;
    assign w_sum = SCORE_W'(s3_pf) + SCORE_W'(s3_pr) + SCORE_W'(s3_pt) + SCORE_W'(s3_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load_req) begin
            r_found <= 1'b0;
        end else if (s3_v && (!r_found || w_sum > r_best)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_v && (!r_found || w_sum > r_best)) begin
            r_best     <= w_sum;
            r_best_idx <= s3_idx;
        end
    end

    // status
    always_comb begin
        o_sts.hit   = i_cmd.scan && w_elig && !r_ref[r_pos] && (r_mod[r_pos] == i_cmd.round2);
        o_sts.last  = (r_pos == w_end);
        o_sts.empty = (r_n == '0);
        o_sts.found = r_found;
        o_sts.pos   = (i_cmd.scan || i_cmd.clr_ref || i_cmd.score) ? r_pos : r_best_idx;
    end

`ifndef SYNTHESIS
    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_n != '0) |-> (CNT_W'(r_hand) < r_n))
        else $error("hand beyond sweep size");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.score |-> (CNT_W'(r_pos) < r_n))
        else $error("score position beyond sweep");
    a_hit_elig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.hit |-> (r_occ[r_pos] && !r_pin[r_pos]))
        else $error("hit on ineligible frame");
`endif

endmodule
